FILE: rtl/ple_pkg.sv
// Package for the positional list engine: opcodes, status codes and
// default sizes shared by the controller and the top level.
// No dependencies.
`timescale 1ns / 1ps

package ple_pkg;

  localparam int PLE_CAPACITY    = 16;
  localparam int PLE_ENTRY_WIDTH = 32;

  // Fixed widths of the channel fields.
  localparam int OP_W    = 3;
  localparam int POS_W   = 5;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 3'd0,
    OP_DELETE   = 3'd1,
    OP_RETRIEVE = 3'd2,
    OP_REPLACE  = 3'd3,
    OP_TRAVERSE = 3'd4,
    OP_CLEAR    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

endpackage

FILE: rtl/ple_store.sv
// Entry store of the positional list engine: one write port and one
// registered read port. Depends on ple_pkg for default sizes.
`timescale 1ns / 1ps

module ple_store import ple_pkg::*; #(
  parameter int DEPTH = PLE_CAPACITY,
  parameter int WIDTH = PLE_ENTRY_WIDTH,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Contents have no reset; only entries below the count are ever read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/ple_ctrl.sv
// Sequencer of the positional list engine: decodes a request, walks the
// entry store one entry at a time and holds the result register.
// Depends on ple_pkg; drives the ports of ple_store.
`timescale 1ns / 1ps

module ple_ctrl import ple_pkg::*; #(
  parameter int CAPACITY    = PLE_CAPACITY,
  parameter int ENTRY_WIDTH = PLE_ENTRY_WIDTH,
  localparam int AW         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int IW         = $clog2(CAPACITY + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [OP_W-1:0]        in_op,
  input  logic [POS_W-1:0]       in_pos,
  input  logic [ENTRY_WIDTH-1:0] in_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ENTRY_WIDTH-1:0] out_item,
  output logic [1:0]             out_status,
  output logic [IW-1:0]          out_count,
  output logic                   out_is_empty,
  output logic                   out_is_full,
  output logic                   out_last,
  output logic                   mem_wr_en,
  output logic [AW-1:0]          mem_wr_addr,
  output logic [ENTRY_WIDTH-1:0] mem_wr_data,
  output logic [AW-1:0]          mem_rd_addr,
  input  logic [ENTRY_WIDTH-1:0] mem_rd_data
);

  localparam int CMPW = (IW > POS_W) ? IW : POS_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_PUT,
    S_HEAD,
    S_TAKE,
    S_DEL_RD,
    S_DEL_WR,
    S_RESULT
  } state_t;

  state_t                 state_r;
  op_t                    op_r;
  logic [IW-1:0]          idx_r;
  logic [IW-1:0]          pos_r;
  logic [IW-1:0]          count_r;
  logic [ENTRY_WIDTH-1:0] val_r;
  logic [ENTRY_WIDTH-1:0] item_r;
  status_t                status_r;
  logic                   last_r;

  logic                   out_valid_r;
  logic [ENTRY_WIDTH-1:0] out_item_r;
  status_t                out_status_r;
  logic [IW-1:0]          out_count_r;
  logic                   out_is_empty_r;
  logic                   out_is_full_r;
  logic                   out_last_r;

  logic [IW-1:0]   idx_dec;
  logic [IW-1:0]   idx_inc;
  logic [IW-1:0]   wr_idx;
  logic [IW-1:0]   rd_idx;
  logic [CMPW-1:0] pos_c;
  logic [CMPW-1:0] cnt_c;
  logic            count_full;
  logic            count_zero;
  logic            res_load;

  assign idx_dec    = idx_r - 1'b1;
  assign idx_inc    = idx_r + 1'b1;
  assign pos_c      = CMPW'(in_pos);
  assign cnt_c      = CMPW'(count_r);
  assign count_full = (count_r == IW'(CAPACITY));
  assign count_zero = (count_r == '0);
  assign res_load   = !out_valid_r || out_ready;

  // Insert moves entry idx-1 up to idx; delete moves entry idx down to idx-1.
  assign rd_idx      = (state_r == S_INS_RD) ? idx_dec : idx_r;
  assign wr_idx      = (state_r == S_DEL_WR) ? idx_dec : idx_r;
  assign mem_rd_addr = rd_idx[AW-1:0];
  assign mem_wr_addr = wr_idx[AW-1:0];
  assign mem_wr_en   = (state_r == S_INS_WR) || (state_r == S_DEL_WR) || (state_r == S_PUT);
  assign mem_wr_data = (state_r == S_PUT) ? val_r : mem_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_RESULT && res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r   <= op_t'(in_op);
            val_r  <= in_value;
            pos_r  <= IW'(in_pos);
            item_r <= '0;
            last_r <= 1'b1;
            unique case (in_op)
              OP_INSERT: begin
                if (count_full) begin
                  status_r <= ST_FULL;
                  state_r  <= S_RESULT;
                end else if (pos_c > cnt_c) begin
                  status_r <= ST_RANGE;
                  state_r  <= S_RESULT;
                end else begin
                  status_r <= ST_OK;
                  idx_r    <= count_r;
                  state_r  <= (cnt_c > pos_c) ? S_INS_RD : S_PUT;
                end
              end
              OP_DELETE, OP_RETRIEVE, OP_REPLACE: begin
                if (pos_c >= cnt_c) begin
                  status_r <= ST_RANGE;
                  state_r  <= S_RESULT;
                end else begin
                  status_r <= ST_OK;
                  idx_r    <= IW'(in_pos);
                  state_r  <= (in_op == OP_REPLACE) ? S_PUT : S_HEAD;
                end
              end
              OP_TRAVERSE: begin
                status_r <= ST_OK;
                if (!count_zero) begin
                  idx_r   <= '0;
                  state_r <= S_HEAD;
                end else begin
                  state_r <= S_RESULT;
                end
              end
              OP_CLEAR: begin
                status_r <= ST_OK;
                count_r  <= '0;
                state_r  <= S_RESULT;
              end
              default: begin
                status_r <= ST_OK;
                state_r  <= S_RESULT;
              end
            endcase
          end
        end
        S_INS_RD: begin
          state_r <= S_INS_WR;
        end
        S_INS_WR: begin
          // The walk stops with idx at the insert position.
          idx_r   <= idx_dec;
          state_r <= (idx_dec > pos_r) ? S_INS_RD : S_PUT;
        end
        S_PUT: begin
          if (op_r == OP_INSERT) begin
            count_r <= count_r + 1'b1;
          end
          state_r <= S_RESULT;
        end
        S_HEAD: begin
          state_r <= S_TAKE;
        end
        S_TAKE: begin
          item_r <= mem_rd_data;
          if (op_r == OP_DELETE) begin
            idx_r <= idx_inc;
            if (idx_inc < count_r) begin
              state_r <= S_DEL_RD;
            end else begin
              count_r <= count_r - 1'b1;
              state_r <= S_RESULT;
            end
          end else begin
            last_r  <= (op_r != OP_TRAVERSE) || (idx_inc == count_r);
            state_r <= S_RESULT;
          end
        end
        S_DEL_RD: begin
          state_r <= S_DEL_WR;
        end
        S_DEL_WR: begin
          idx_r <= idx_inc;
          if (idx_inc < count_r) begin
            state_r <= S_DEL_RD;
          end else begin
            count_r <= count_r - 1'b1;
            state_r <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (res_load) begin
            out_item_r     <= item_r;
            out_status_r   <= status_r;
            out_count_r    <= count_r;
            out_is_empty_r <= count_zero;
            out_is_full_r  <= count_full;
            out_last_r     <= last_r;
            if (op_r == OP_TRAVERSE && !last_r) begin
              idx_r   <= idx_inc;
              state_r <= S_HEAD;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_item     = out_item_r;
  assign out_status   = out_status_r;
  assign out_count    = out_count_r;
  assign out_is_empty = out_is_empty_r;
  assign out_is_full  = out_is_full_r;
  assign out_last     = out_last_r;

endmodule

FILE: rtl/positional_list_engine.sv
// Retrieve reads the entry at pos (head, take); delete does too, then moves
// each later entry down (read, write); insert moves each entry from pos up
// (read, write), then puts; replace puts. Traverse repeats head, take and
// result per entry. Each read of the entry store is registered. A new request
// is taken the cycle after its last result is registered. Reset clears the
// count and result valid flag, not the store, which needs no clearing pass.
`timescale 1ns / 1ps

module positional_list_engine import ple_pkg::*; #(
  parameter int CAPACITY    = PLE_CAPACITY,
  parameter int ENTRY_WIDTH = PLE_ENTRY_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    in_op,
  input  logic [POS_W-1:0]   in_pos,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [VALUE_W-1:0] out_item_value,
  output logic [1:0]         out_status,
  output logic [COUNT_W-1:0] out_count,
  output logic               out_is_empty,
  output logic               out_is_full,
  output logic               out_last
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int IW = $clog2(CAPACITY + 1);

  logic [ENTRY_WIDTH-1:0] value_w;
  logic [ENTRY_WIDTH-1:0] item_w;
  logic [IW-1:0]          count_w;
  logic                   mem_wr_en;
  logic [AW-1:0]          mem_wr_addr;
  logic [ENTRY_WIDTH-1:0] mem_wr_data;
  logic [AW-1:0]          mem_rd_addr;
  logic [ENTRY_WIDTH-1:0] mem_rd_data;

  // Entries keep only their low ENTRY_WIDTH bits.
  assign value_w        = ENTRY_WIDTH'(in_value);
  assign out_item_value = VALUE_W'(item_w);
  assign out_count      = COUNT_W'(count_w);

  ple_ctrl #(
    .CAPACITY    (CAPACITY),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_pos       (in_pos),
    .in_value     (value_w),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_item     (item_w),
    .out_status   (out_status),
    .out_count    (count_w),
    .out_is_empty (out_is_empty),
    .out_is_full  (out_is_full),
    .out_last     (out_last),
    .mem_wr_en    (mem_wr_en),
    .mem_wr_addr  (mem_wr_addr),
    .mem_wr_data  (mem_wr_data),
    .mem_rd_addr  (mem_rd_addr),
    .mem_rd_data  (mem_rd_data)
  );

  ple_store #(
    .DEPTH (CAPACITY),
    .WIDTH (ENTRY_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

`ifndef ASSERT_OFF
  // One request at a time: a transfer on the input always takes the engine out of idle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after a transfer");

  // A flagged request is a single result and reads nothing.
  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_last && out_item_value == '0))
    else $error("error result is not a single empty result");

  // Insert is only refused for fullness when the list is in fact full.
  a_full_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_is_full && !out_is_empty))
    else $error("full status without a full list");
`endif

endmodule
